FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// clocked assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk, off during reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication from a qualifying condition to an expected condition
`define ASSERT_IMPLY(label, cond, expect_cond, msg) \
  `ASSERT_CLK(label, (cond) |-> (expect_cond), msg)

`endif

FILE: hw/rtl/rbfp_pkg.sv
// ----------------------------------------------------------------------------
// rbfp_pkg
// shared constants and codes of the box face projection block
// ----------------------------------------------------------------------------
package rbfp_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int DIR_WIDTH_DEF   = 16;

  localparam int LANES  = 10;
  localparam int FACES  = 5;
  localparam int AXES   = 3;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  typedef enum logic [2:0] {
    FACE_ROOF  = 3'd0,
    FACE_Z_MIN = 3'd1,
    FACE_Z_MAX = 3'd2,
    FACE_X_MIN = 3'd3,
    FACE_X_MAX = 3'd4
  } face_t;

  typedef enum logic [2:0] {
    REG_X_MIN = 3'd0,
    REG_X_MAX = 3'd1,
    REG_Y_MIN = 3'd2,
    REG_Y_MAX = 3'd3,
    REG_Z_MIN = 3'd4,
    REG_Z_MAX = 3'd5
  } reg_idx_t;

  // two projection lanes per face: normal axis and projected axis of each
  localparam int LANE_NORM  [LANES] = '{1, 1, 2, 2, 2, 2, 0, 0, 0, 0};
  localparam int LANE_OTHER [LANES] = '{0, 2, 0, 1, 0, 1, 2, 1, 2, 1};
  localparam int FACE_NORM  [FACES] = '{1, 2, 2, 0, 0};
  localparam bit FACE_HI    [FACES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

endpackage

FILE: hw/rtl/ray_box_face_projection.sv
// ----------------------------------------------------------------------------
// ray_box_face_projection
// projects a line onto the roof and four sides of a box, reports best face
// ----------------------------------------------------------------------------
// input beats carry a line origin and direction; each gives one output beat
// with hit, face and the crossing point of greatest y (earliest face on tie).
// both channels use valid/stall; a beat moves when valid is high and stall low.
// one beat is taken every cycle while the output is not stalled.
// a divider chain of one quotient bit per stage runs in each of the ten
// projection lanes. a stalled output beat holds, the whole pipeline freezes
// and in_stall rises in the same cycle, so nothing is lost or repeated.
// box bounds are to be written over the apb port only while the block is
// idle; the block itself does not enforce this. reset clears all bounds
// to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module ray_box_face_projection
  import rbfp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int DIR_WIDTH   = DIR_WIDTH_DEF,
  localparam int DATA_W     = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_W     = (COORD_WIDTH > 32) ? 6 : 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] origin_x,
  input  logic signed [COORD_WIDTH-1:0] origin_y,
  input  logic signed [COORD_WIDTH-1:0] origin_z,
  input  logic signed [DIR_WIDTH-1:0]   dir_x,
  input  logic signed [DIR_WIDTH-1:0]   dir_y,
  input  logic signed [DIR_WIDTH-1:0]   dir_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          hit,
  output logic [2:0]                    face,
  output logic signed [COORD_WIDTH-1:0] hit_x,
  output logic signed [COORD_WIDTH-1:0] hit_y,
  output logic signed [COORD_WIDTH-1:0] hit_z
);

`include "assert_macros.svh"

  localparam int CW = COORD_WIDTH;
  localparam int DW = DIR_WIDTH;
  localparam int N  = CW + DW;
  localparam int MW = CW + 2;
  localparam int PW = CW + 3;
  localparam logic [N-1:0] LIMIT = N'(1) << (CW + 1);

  // box bounds per axis
  logic signed [CW-1:0] bnd_lo [AXES];
  logic signed [CW-1:0] bnd_hi [AXES];

  logic              wr;
  logic [2:0]        wr_idx;
  logic signed [CW-1:0] wr_val;
  logic signed [CW-1:0] rd_val;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign wr_idx = paddr[ADDR_W-1 -: 3];
  assign wr_val = pwdata[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        bnd_lo[a] <= '0;
        bnd_hi[a] <= '0;
      end
    end else if (wr) begin
      case (reg_idx_t'(wr_idx))
        REG_X_MIN: bnd_lo[AXIS_X] <= wr_val;
        REG_X_MAX: bnd_hi[AXIS_X] <= wr_val;
        REG_Y_MIN: bnd_lo[AXIS_Y] <= wr_val;
        REG_Y_MAX: bnd_hi[AXIS_Y] <= wr_val;
        REG_Z_MIN: bnd_lo[AXIS_Z] <= wr_val;
        REG_Z_MAX: bnd_hi[AXIS_Z] <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(wr_idx))
      REG_X_MIN: rd_val = bnd_lo[AXIS_X];
      REG_X_MAX: rd_val = bnd_hi[AXIS_X];
      REG_Y_MIN: rd_val = bnd_lo[AXIS_Y];
      REG_Y_MAX: rd_val = bnd_hi[AXIS_Y];
      REG_Z_MIN: rd_val = bnd_lo[AXIS_Z];
      REG_Z_MAX: rd_val = bnd_hi[AXIS_Z];
      default:   rd_val = '0;
    endcase
    prdata = DATA_W'(rd_val);
    if (DATA_W > CW) begin
      prdata = {{(DATA_W-CW){rd_val[CW-1]}}, rd_val} ;
    end
  end

  // pipeline advance
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  function automatic logic signed [CW-1:0] plane_of(input int f);
    return FACE_HI[f] ? bnd_hi[FACE_NORM[f]] : bnd_lo[FACE_NORM[f]];
  endfunction

  function automatic logic [DW+N-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [N-1:0]  pq,
                                                input logic [DW-1:0] d);
    logic [DW:0] trial;
    logic        ge;
    trial = {rem, pq[N-1]};
    ge    = trial >= {1'b0, d};
    if (ge) begin
      trial = trial - {1'b0, d};
    end
    return {trial[DW-1:0], pq[N-2:0], ge};
  endfunction

  // input register
  logic                 v1;
  logic signed [CW-1:0] org1 [AXES];
  logic signed [DW-1:0] dir1 [AXES];

  // operand stage
  logic                 v2;
  logic [CW:0]          a2   [LANES];
  logic [DW-1:0]        b2   [LANES];
  logic                 neg2 [LANES];
  logic signed [CW-1:0] org2 [AXES];
  logic [DW-1:0]        d2   [AXES];
  logic                 skip2 [AXES];

  logic [CW:0]          a_c   [LANES];
  logic [DW-1:0]        b_c   [LANES];
  logic                 neg_c [LANES];
  logic [DW-1:0]        d_c   [AXES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic signed [CW:0] diff;
      logic signed [CW-1:0] pl;
      pl       = plane_of(l / 2);
      diff     = {pl[CW-1], pl} - {org1[LANE_NORM[l]][CW-1], org1[LANE_NORM[l]]};
      a_c[l]   = diff[CW] ? (CW+1)'(-diff) : diff;
      b_c[l]   = dir1[LANE_OTHER[l]][DW-1] ? DW'(-dir1[LANE_OTHER[l]])
                                           : dir1[LANE_OTHER[l]];
      neg_c[l] = diff[CW] ^ dir1[LANE_OTHER[l]][DW-1] ^ dir1[LANE_NORM[l]][DW-1];
    end
    for (int a = 0; a < AXES; a++) begin
      d_c[a] = dir1[a][DW-1] ? DW'(-dir1[a]) : dir1[a];
    end
  end

  // divider chain: stage 0 holds the product
  logic                 dv    [N+1];
  logic [N-1:0]         dpq   [N+1][LANES];
  logic [DW-1:0]        drem  [N+1][LANES];
  logic                 dneg  [N+1][LANES];
  logic signed [CW-1:0] dorg  [N+1][AXES];
  logic [DW-1:0]        dd    [N+1][AXES];
  logic                 dskip [N+1][AXES];

  // point, face test and selection stages
  logic                 v4, v5, v6, v7;
  logic signed [PW-1:0] pt4  [LANES];
  logic                 skip4 [AXES];
  logic signed [PW-1:0] cx5  [FACES][AXES];
  logic                 ps5  [FACES];

  logic signed [PW-1:0] pt_c [LANES];
  logic signed [PW-1:0] cx_c [FACES][AXES];
  logic                 ps_c [FACES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [MW-1:0]        mag;
      logic signed [PW-1:0] base;
      mag  = (dpq[N][l] > LIMIT) ? LIMIT[MW-1:0] : dpq[N][l][MW-1:0];
      base = PW'(dorg[N][LANE_OTHER[l]]);
      pt_c[l] = dneg[N][l] ? base - PW'(mag) : base + PW'(mag);
    end
  end

  always_comb begin
    for (int f = 0; f < FACES; f++) begin
      logic signed [CW-1:0] pl;
      pl      = plane_of(f);
      ps_c[f] = !skip4[FACE_NORM[f]];
      for (int a = 0; a < AXES; a++) begin
        if (a == FACE_NORM[f]) begin
          cx_c[f][a] = PW'(pl);
        end else if (a == LANE_OTHER[2*f]) begin
          cx_c[f][a] = pt4[2*f];
        end else begin
          cx_c[f][a] = pt4[2*f+1];
        end
        if (a != FACE_NORM[f]) begin
          ps_c[f] = ps_c[f] && (cx_c[f][a] >= PW'(bnd_lo[a]))
                            && (cx_c[f][a] <= PW'(bnd_hi[a]));
        end
      end
    end
  end

  // earlier candidate a, later candidate b: take b only on strictly greater y
  function automatic logic take_b(input logic pa, input logic signed [PW-1:0] ya,
                                  input logic pb, input logic signed [PW-1:0] yb);
    return pb && (!pa || (yb > ya));
  endfunction

  logic signed [PW-1:0] c6 [3][AXES];
  logic                 p6 [3];
  logic [2:0]           f6 [3];
  logic signed [PW-1:0] c7 [2][AXES];
  logic                 p7 [2];
  logic [2:0]           f7 [2];

  logic tb01, tb23, tb7;
  assign tb01 = take_b(ps5[0], cx5[0][AXIS_Y], ps5[1], cx5[1][AXIS_Y]);
  assign tb23 = take_b(ps5[2], cx5[2][AXIS_Y], ps5[3], cx5[3][AXIS_Y]);
  logic tb6;
  assign tb6  = take_b(p6[0], c6[0][AXIS_Y], p6[1], c6[1][AXIS_Y]);
  assign tb7  = take_b(p7[0], c7[0][AXIS_Y], p7[1], c7[1][AXIS_Y]);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int j = 0; j <= N; j++) begin
        dv[j] <= 1'b0;
      end
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1    <= in_valid;
      v2    <= v1;
      dv[0] <= v2;
      for (int j = 0; j < N; j++) begin
        dv[j+1] <= dv[j];
      end
      v4        <= dv[N];
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      out_valid <= v7;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      org1[AXIS_X] <= origin_x;
      org1[AXIS_Y] <= origin_y;
      org1[AXIS_Z] <= origin_z;
      dir1[AXIS_X] <= dir_x;
      dir1[AXIS_Y] <= dir_y;
      dir1[AXIS_Z] <= dir_z;

      for (int l = 0; l < LANES; l++) begin
        a2[l]   <= a_c[l];
        b2[l]   <= b_c[l];
        neg2[l] <= neg_c[l];
      end
      for (int a = 0; a < AXES; a++) begin
        org2[a]  <= org1[a];
        d2[a]    <= d_c[a];
        skip2[a] <= (dir1[a] == '0);
      end

      for (int l = 0; l < LANES; l++) begin
        dpq[0][l]  <= N'(a2[l] * b2[l]);
        drem[0][l] <= '0;
        dneg[0][l] <= neg2[l];
      end
      for (int a = 0; a < AXES; a++) begin
        dorg[0][a]  <= org2[a];
        dd[0][a]    <= d2[a];
        dskip[0][a] <= skip2[a];
      end

      for (int j = 0; j < N; j++) begin
        for (int l = 0; l < LANES; l++) begin
          {drem[j+1][l], dpq[j+1][l]} <= div_step(drem[j][l], dpq[j][l],
                                                  dd[j][LANE_NORM[l]]);
          dneg[j+1][l] <= dneg[j][l];
        end
        for (int a = 0; a < AXES; a++) begin
          dorg[j+1][a]  <= dorg[j][a];
          dd[j+1][a]    <= dd[j][a];
          dskip[j+1][a] <= dskip[j][a];
        end
      end

      for (int l = 0; l < LANES; l++) begin
        pt4[l] <= pt_c[l];
      end
      for (int a = 0; a < AXES; a++) begin
        skip4[a] <= dskip[N][a];
      end

      for (int f = 0; f < FACES; f++) begin
        ps5[f] <= ps_c[f];
        for (int a = 0; a < AXES; a++) begin
          cx5[f][a] <= cx_c[f][a];
        end
      end

      p6[0] <= tb01 ? ps5[1] : ps5[0];
      f6[0] <= tb01 ? FACE_Z_MIN : FACE_ROOF;
      p6[1] <= tb23 ? ps5[3] : ps5[2];
      f6[1] <= tb23 ? FACE_X_MIN : FACE_Z_MAX;
      p6[2] <= ps5[4];
      f6[2] <= FACE_X_MAX;
      for (int a = 0; a < AXES; a++) begin
        c6[0][a] <= tb01 ? cx5[1][a] : cx5[0][a];
        c6[1][a] <= tb23 ? cx5[3][a] : cx5[2][a];
        c6[2][a] <= cx5[4][a];
      end

      p7[0] <= tb6 ? p6[1] : p6[0];
      f7[0] <= tb6 ? f6[1] : f6[0];
      p7[1] <= p6[2];
      f7[1] <= f6[2];
      for (int a = 0; a < AXES; a++) begin
        c7[0][a] <= tb6 ? c6[1][a] : c6[0][a];
        c7[1][a] <= c6[2][a];
      end

      if (tb7 || p7[0]) begin
        hit   <= 1'b1;
        face  <= tb7 ? f7[1] : f7[0];
        hit_x <= tb7 ? c7[1][AXIS_X][CW-1:0] : c7[0][AXIS_X][CW-1:0];
        hit_y <= tb7 ? c7[1][AXIS_Y][CW-1:0] : c7[0][AXIS_Y][CW-1:0];
        hit_z <= tb7 ? c7[1][AXIS_Z][CW-1:0] : c7[0][AXIS_Z][CW-1:0];
      end else begin
        hit   <= 1'b0;
        face  <= '0;
        hit_x <= '0;
        hit_y <= '0;
        hit_z <= '0;
      end
    end
  end

  `ASSERT_IMPLY(a_miss_zero, out_valid && !hit,
                face == '0 && hit_x == '0 && hit_y == '0 && hit_z == '0,
                "miss beat carries nonzero payload")
  `ASSERT_IMPLY(a_roof_y, out_valid && hit && face == FACE_ROOF,
                hit_y == bnd_hi[AXIS_Y], "roof hit off the roof plane")
  `ASSERT_IMPLY(a_side_in_box,
                out_valid && hit && (face == FACE_Z_MIN || face == FACE_Z_MAX),
                hit_x >= bnd_lo[AXIS_X] && hit_x <= bnd_hi[AXIS_X]
                && hit_y >= bnd_lo[AXIS_Y] && hit_y <= bnd_hi[AXIS_Y],
                "z face hit outside face rectangle")

endmodule

FILE: dv/ray_box_face_projection_tb.sv
// ----------------------------------------------------------------------------
// ray_box_face_projection_tb
// self-checking bench for the box face projection block: lines are driven
// with random idling on both sides, each output beat is compared with a
// predictor of the five face projections, bounds are changed between phases
// ----------------------------------------------------------------------------
module ray_box_face_projection_tb;
  import rbfp_pkg::*;

  localparam int CW = 32;
  localparam int DW = 16;
  localparam int LATENCY = CW + DW + 8;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] oz;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
  } line_t;

  typedef struct packed {
    logic                 hit;
    logic [2:0]           face;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } crossing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [DW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [2:0] face;
  logic signed [CW-1:0] hit_x, hit_y, hit_z;

  ray_box_face_projection u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .face(face), .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z)
  );

  longint bx_min, bx_max, by_min, by_max, bz_min, bz_max;
  crossing_t expected_crossings[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("ray_box_face_projection_tb: FAIL");
    $finish;
  end

  function automatic longint project_axis(longint base_o, longint plane, longint base_a,
                                          longint d_o, longint d_a);
    logic signed [127:0] num;
    logic signed [127:0] q;
    logic signed [127:0] lim;
    num = 128'(signed'(plane - base_a)) * 128'(signed'(d_o));
    q = num / 128'(signed'(d_a));
    lim = 128'sd1 <<< (CW + 1);
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return base_o + longint'(q);
  endfunction

  function automatic crossing_t best_crossing(line_t l);
    crossing_t r;
    longint ox, oy, oz, dx, dy, dz, px, py, pz;
    bit pass, found;
    ox = l.ox; oy = l.oy; oz = l.oz; dx = l.dx; dy = l.dy; dz = l.dz;
    r = '0;
    found = 0;
    for (int f = 0; f < FACES; f++) begin
      if (f == FACE_ROOF) begin
        if (dy == 0) continue;
        py = by_max;
        px = project_axis(ox, py, oy, dx, dy);
        pz = project_axis(oz, py, oy, dz, dy);
        pass = px >= bx_min && px <= bx_max && pz >= bz_min && pz <= bz_max;
      end else if (f == FACE_Z_MIN || f == FACE_Z_MAX) begin
        if (dz == 0) continue;
        pz = (f == FACE_Z_MIN) ? bz_min : bz_max;
        px = project_axis(ox, pz, oz, dx, dz);
        py = project_axis(oy, pz, oz, dy, dz);
        pass = px >= bx_min && px <= bx_max && py >= by_min && py <= by_max;
      end else begin
        if (dx == 0) continue;
        px = (f == FACE_X_MIN) ? bx_min : bx_max;
        pz = project_axis(oz, px, ox, dz, dx);
        py = project_axis(oy, px, ox, dy, dx);
        pass = pz >= bz_min && pz <= bz_max && py >= by_min && py <= by_max;
      end
      if (pass && (!found || py > longint'(r.y))) begin
        found = 1;
        r.hit = 1'b1;
        r.face = 3'(f);
        r.x = px[CW-1:0]; r.y = py[CW-1:0]; r.z = pz[CW-1:0];
      end
    end
    return r;
  endfunction

  task automatic write_bound(reg_idx_t idx, logic signed [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(idx) << 2; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_X_MIN: bx_min = value;
      REG_X_MAX: bx_max = value;
      REG_Y_MIN: by_min = value;
      REG_Y_MAX: by_max = value;
      REG_Z_MIN: bz_min = value;
      default:   bz_max = value;
    endcase
  endtask

  task automatic set_box(int x0, int x1, int y0, int y1, int z0, int z1);
    write_bound(REG_X_MIN, x0); write_bound(REG_X_MAX, x1);
    write_bound(REG_Y_MIN, y0); write_bound(REG_Y_MAX, y1);
    write_bound(REG_Z_MIN, z0); write_bound(REG_Z_MAX, z1);
  endtask

  task automatic drain();
    while (expected_crossings.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // valid only drops when the next beat is idle, so no double assignment
  task automatic send_line(line_t l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_crossings = {expected_crossings, best_crossing(l)};
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  function automatic int pick_coord(int scale);
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return $urandom_range(2 * scale) - scale;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_dir();
    case ($urandom_range(9))
      0: return 16'sd0;
      1: return 16'sh7fff;
      2: return 16'sh8000;
      3: return 16'($urandom_range(7) - 3);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic line_t random_line(int scale);
    line_t l;
    l.ox = pick_coord(scale); l.oy = pick_coord(scale); l.oz = pick_coord(scale);
    l.dx = pick_dir(); l.dy = pick_dir(); l.dz = pick_dir();
    return l;
  endfunction

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    crossing_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_crossings.size() == 0) begin
        $error("unexpected output beat");
        errors++;
      end else begin
        e = expected_crossings.pop_front();
        if (hit !== e.hit) begin
          $error("hit expected %0d actual %0d", e.hit, hit); errors++;
        end
        if (face !== e.face) begin
          $error("face expected %0d actual %0d", e.face, face); errors++;
        end
        if (hit_x !== e.x) begin
          $error("hit_x expected %0d actual %0d", e.x, hit_x); errors++;
        end
        if (hit_y !== e.y) begin
          $error("hit_y expected %0d actual %0d", e.y, hit_y); errors++;
        end
        if (hit_z !== e.z) begin
          $error("hit_z expected %0d actual %0d", e.z, hit_z); errors++;
        end
      end
    end
  end

  task automatic test_reset_box();
    line_t l;
    l = '{0, 5, 0, 0, -16'sd1, 0};
    send_line(l);
    l = '{0, 0, 0, 1, 1, 1};
    send_line(l);
    end_burst();
    drain();
  endtask

  task automatic test_directed();
    line_t l;
    set_box(-1000, 1000, -500, 500, -2000, 2000);
    l = '{0, 1000, 0, 0, -16'sd100, 0};      send_line(l);   // roof center
    l = '{1000, 1000, 2000, 0, -16'sd1, 0};  send_line(l);   // roof corner edge
    l = '{1001, 1000, 0, 0, -16'sd1, 0};     send_line(l);   // just outside
    l = '{0, 0, -5000, 0, 0, 16'sd7};        send_line(l);   // z faces
    l = '{-5000, 0, 0, 16'sd3, 0, 0};        send_line(l);   // x faces
    l = '{0, 0, 0, 16'sd1, 16'sd1, 16'sd1};  send_line(l);   // diagonal, roof only
    l = '{0, 0, 0, 0, 0, 0};                 send_line(l);   // all skipped
    l = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
          16'sh8000, 16'sh7fff, 16'sh8000};  send_line(l);   // overflow
    l = '{0, 0, 0, 16'sh7fff, 16'sh0001, 16'sh8000}; send_line(l);
    l = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
          16'sh0001, 16'sh8000, 16'sh0001};  send_line(l);
    end_burst();
    drain();
    set_box(10, -10, -500, 500, -2000, 2000);  // reversed x range
    l = '{0, 1000, 0, 0, -16'sd1, 0};        send_line(l);
    l = '{0, 0, -5000, 16'sd1, 16'sd2, 16'sd9}; send_line(l);
    end_burst();
    drain();
    set_box(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
            32'sh80000000, 32'sh7fffffff);
    l = '{-7, 3, 9, 16'sd5, -16'sd4, 16'sd2}; send_line(l);
    l = '{32'sh7fffffff, 0, 0, 16'sh8000, 16'sh7fff, 16'sd1}; send_line(l);
    end_burst();
    drain();
  endtask

  task automatic test_random_phase(int count, int scale, int s_pct, int r_pct);
    int lo, hi;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    lo = -int'($urandom_range(scale)); hi = $urandom_range(scale);
    set_box(lo, hi, -int'($urandom_range(scale)), $urandom_range(scale),
            -int'($urandom_range(scale)), $urandom_range(scale));
    for (int i = 0; i < count; i++) send_line(random_line(2 * scale));
    end_burst();
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 200;
    for (int i = 0; i < 120; i++) send_line(random_line(4000));
    end_burst();
    drain();
  endtask

  initial begin
    bx_min = 0; bx_max = 0; by_min = 0; by_max = 0; bz_min = 0; bz_max = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_box();
    test_directed();
    test_random_phase(200, 5000, 28, 87);
    test_random_phase(200, 100000, 87, 28);
    test_random_phase(160, 1 << 20, 0, 0);
    test_backpressure();
    if (errors == 0) $display("ray_box_face_projection_tb: PASS");
    else $display("ray_box_face_projection_tb: FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rbfp_pkg.sv
hw/rtl/ray_box_face_projection.sv
dv/ray_box_face_projection_tb.sv
